@@ rtl/core/pfc_pkg.sv @@
`default_nettype none

package pfc_pkg;

  typedef enum logic [1:0] {
    CMD_KEY    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_PLAIN  = 2'd2,
    CMD_CIPHER = 2'd3
  } cmd_t;

  localparam int unsigned LETTERS  = 26;
  localparam int unsigned LETTER_W = 5;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;
  localparam logic [LETTER_W-1:0] SQ_CELLS = 5'd25;

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [4:0] row_base(input logic [2:0] r);
    return 5'({r, 2'b00}) + 5'(r);
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [4:0] c;
    c = p - row_base(row_of(p));
    return c[2:0];
  endfunction

  // rotate one place along a row or column, forward or back
  function automatic logic [2:0] step5(input logic [2:0] x, input logic back);
    logic [2:0] y;
    if (back) begin
      y = (x == 3'd0) ? 3'd4 : x - 3'd1;
    end else begin
      y = (x == 3'd4) ? 3'd0 : x + 3'd1;
    end
    return y;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return row_base(r) + 5'(c);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pfc_ram.sv @@
`default_nettype none

module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/playfair_digraph_cipher.sv @@
// Playfair cipher engine, 5x5 square with j folded into i.
// Input stream: s_tdata carries a command and a letter, s_tlast marks the
// final letter of a message or key. Key letters fill the square, a finish
// command completes it in alphabet order, plaintext and ciphertext letters
// are paired and transformed. Output stream: one letter per word, m_tlast on
// the last word caused by one input word, m_tuser flags an odd ciphertext tail.
// Timing: the engine takes one input word at a time. A completed digraph
// reaches the output register through the states RDA, RDB, CALC, SQA, SQB,
// SQC and EMIT, set by the serial lookups through the position RAM and the
// square RAM (one read port each). A finish command walks the alphabet, one
// letter a cycle.
// The output register lets the next word be taken while a result waits;
// while m_tready is low the engine holds at its next result and s_tready
// stays low once it is back waiting for that register.
// Reset empties the square and drops any pending letter; the engine is
// ready on the cycle after reset.
`default_nettype none

module playfair_digraph_cipher (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [1:0] command, [6:2] letter, [7] zero
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [4:0] out_letter, [7:5] zero
  output logic            m_tlast,
  output logic            m_tuser    // [0] status
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_EXEC = 11'b000_0000_0010,
    ST_WALK = 11'b000_0000_0100,
    ST_RDA  = 11'b000_0000_1000,
    ST_RDB  = 11'b000_0001_0000,
    ST_CALC = 11'b000_0010_0000,
    ST_SQA  = 11'b000_0100_0000,
    ST_SQB  = 11'b000_1000_0000,
    ST_SQC  = 11'b001_0000_0000,
    ST_EMIT = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } state_t;

  state_t        state;
  pfc_pkg::cmd_t cmd;
  logic [4:0]    letter;
  logic          item_end;
  logic          item_ok;
  logic [25:0]   present;
  logic [4:0]    fill;
  logic [4:0]    pend_letter;
  logic          pend_valid;
  logic [4:0]    walk;
  logic [4:0]    pa;
  logic [4:0]    pb;
  logic          dec;
  logic          twice;
  logic [4:0]    pos_a;
  logic [4:0]    ca;
  logic [4:0]    cb;
  logic [4:0]    res_a;
  logic [4:0]    res_b;
  logic          err;
  logic [1:0]    emit_idx;
  logic [4:0]    out_letter;

  logic [4:0]    pos_rd;
  logic [4:0]    sq_rd;
  logic [4:0]    pos_raddr;
  logic [4:0]    sq_raddr;

  logic          wr_en;
  logic [4:0]    wr_letter;
  logic [4:0]    wr_cell;
  logic [25:0]   present_next;
  logic [4:0]    fill_next;
  logic          full;
  logic [25:0]   base_present;
  logic [4:0]    base_fill;

  logic [2:0]    ar, ac, br, bc;
  logic [4:0]    ca_next, cb_next;
  logic [1:0]    final_idx;
  logic          load;
  logic [4:0]    in_letter;

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign in_letter = s_tdata[6:2];
  assign m_tdata   = {3'b000, out_letter};

  // square and position stores
  pfc_ram #(.WIDTH(5), .DEPTH(25)) u_square (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_cell),
    .wdata (wr_letter),
    .raddr (sq_raddr),
    .rdata (sq_rd)
  );

  pfc_ram #(.WIDTH(5), .DEPTH(26)) u_position (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_letter),
    .wdata (wr_cell),
    .raddr (pos_raddr),
    .rdata (pos_rd)
  );

  assign pos_raddr = (state == ST_RDB) ? pb : pa;
  assign sq_raddr  = (state == ST_SQB) ? cb : ca;

  // key fill and finish walk: a key letter on a full square starts a new square
  always_comb begin
    full         = (fill == pfc_pkg::SQ_CELLS);
    base_present = present;
    base_fill    = fill;
    wr_en        = 1'b0;
    wr_letter    = letter;
    wr_cell      = fill;
    if (state == ST_EXEC && full) begin
      base_present = '0;
      base_fill    = '0;
    end
    if (state == ST_EXEC && cmd == pfc_pkg::CMD_KEY && item_ok) begin
      wr_letter = letter;
      wr_cell   = base_fill;
      wr_en     = !base_present[letter];
    end else if (state == ST_WALK) begin
      wr_letter = walk;
      wr_cell   = fill;
      wr_en     = (walk != pfc_pkg::LETTER_J) && !present[walk] && !full;
    end
    present_next = present;
    fill_next    = fill;
    if (state == ST_EXEC && cmd == pfc_pkg::CMD_KEY && item_ok) begin
      present_next = base_present;
      fill_next    = base_fill;
    end
    if (wr_en) begin
      present_next = present_next | (26'd1 << wr_letter);
      fill_next    = wr_cell + 5'd1;
    end
  end

  // digraph rule on the two looked-up cells
  always_comb begin
    ar = pfc_pkg::row_of(pos_a);
    ac = pfc_pkg::col_of(pos_a);
    br = pfc_pkg::row_of(pos_rd);
    bc = pfc_pkg::col_of(pos_rd);
    if (ar == br) begin
      ca_next = pfc_pkg::cell_of(ar, pfc_pkg::step5(ac, dec));
      cb_next = pfc_pkg::cell_of(br, pfc_pkg::step5(bc, dec));
    end else if (ac == bc) begin
      ca_next = pfc_pkg::cell_of(pfc_pkg::step5(ar, dec), ac);
      cb_next = pfc_pkg::cell_of(pfc_pkg::step5(br, dec), bc);
    end else begin
      ca_next = pfc_pkg::cell_of(ar, bc);
      cb_next = pfc_pkg::cell_of(br, ac);
    end
  end

  assign final_idx = err ? 2'd0 : (twice ? 2'd3 : 2'd1);
  assign load      = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      present    <= '0;
      fill       <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      present <= present_next;
      fill    <= fill_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd == pfc_pkg::CMD_FINISH) begin
            state <= ST_WALK;
          end else if (!item_ok) begin
            state <= ST_IDLE;
          end else if (cmd == pfc_pkg::CMD_KEY) begin
            state <= ST_IDLE;
            if (full) begin
              pend_valid <= 1'b0;
            end
          end else if (!full) begin
            state <= ST_IDLE;
          end else if (!pend_valid) begin
            if (!item_end) begin
              state      <= ST_IDLE;
              pend_valid <= 1'b1;
            end else if (cmd == pfc_pkg::CMD_PLAIN) begin
              state <= ST_RDA;
            end else begin
              state <= ST_EMIT;
            end
          end else if (cmd == pfc_pkg::CMD_PLAIN && pend_letter == letter) begin
            state <= ST_RDA;
            if (item_end) begin
              pend_valid <= 1'b0;
            end
          end else begin
            state      <= ST_RDA;
            pend_valid <= 1'b0;
          end
        end
        ST_WALK: begin
          if (walk == pfc_pkg::LETTER_Z) begin
            state <= ST_IDLE;
          end
        end
        ST_RDA:  state <= ST_RDB;
        ST_RDB:  state <= ST_CALC;
        ST_CALC: state <= ST_SQA;
        ST_SQA:  state <= ST_SQB;
        ST_SQB:  state <= ST_SQC;
        ST_SQC:  state <= ST_EMIT;
        ST_EMIT: begin
          if (load && emit_idx == final_idx) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      cmd      <= pfc_pkg::cmd_t'(s_tdata[1:0]);
      letter   <= (in_letter == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : in_letter;
      item_ok  <= (in_letter <= pfc_pkg::LETTER_Z);
      item_end <= s_tlast;
    end
    if (state == ST_EXEC) begin
      walk     <= '0;
      emit_idx <= '0;
      dec      <= (cmd == pfc_pkg::CMD_CIPHER);
      res_a    <= '0;
      if (!pend_valid) begin
        pend_letter <= letter;
        pa          <= letter;
        pb          <= pfc_pkg::LETTER_X;
        err         <= (cmd == pfc_pkg::CMD_CIPHER);
        twice       <= 1'b0;
      end else if (cmd == pfc_pkg::CMD_PLAIN && pend_letter == letter) begin
        pa    <= letter;
        pb    <= pfc_pkg::LETTER_X;
        err   <= 1'b0;
        twice <= item_end;
      end else begin
        pa    <= pend_letter;
        pb    <= letter;
        err   <= 1'b0;
        twice <= 1'b0;
      end
    end
    if (state == ST_WALK) begin
      walk <= walk + 5'd1;
    end
    if (state == ST_RDB) begin
      pos_a <= pos_rd;
    end
    if (state == ST_CALC) begin
      ca <= ca_next;
      cb <= cb_next;
    end
    if (state == ST_SQB) begin
      res_a <= sq_rd;
    end
    if (state == ST_SQC) begin
      res_b <= sq_rd;
    end
    if (load) begin
      out_letter <= emit_idx[0] ? res_b : res_a;
      m_tlast    <= (emit_idx == final_idx);
      m_tuser    <= err;
      emit_idx   <= emit_idx + 2'd1;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= pfc_pkg::SQ_CELLS)
    else $error("fill count beyond square size");

  a_fill_matches_present: assert property (@(posedge clk) disable iff (rst)
    $countones(present) == int'(fill))
    else $error("fill count disagrees with present letters");

  a_no_j: assert property (@(posedge clk) disable iff (rst)
    !present[pfc_pkg::LETTER_J])
    else $error("letter j entered the square");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error word not marked last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken before first processed");

endmodule

`default_nettype wire

@@ tb/sv/playfair_digraph_cipher_tb.sv @@
`timescale 1ns / 100ps

module playfair_digraph_cipher_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int MSG_WORDS = 100;

  typedef struct packed {
    logic [4:0] letter;
    logic       last;
    logic       status;
  } cipher_word_t;

  class cipher_scoreboard;
    logic [4:0]   square [25];
    logic [4:0]   where [26];
    bit           present [26];
    int unsigned  filled;
    logic [4:0]   held;
    bit           held_valid;
    cipher_word_t due [$];
    int           errors;
    int           words_in;
    int           words_out;
    int           keys_done;
    int           row_pairs;
    int           col_pairs;
    int           rect_pairs;
    int           odd_tails;

    function new();
      clear_square();
      held = '0;
      held_valid = 1'b0;
    endfunction

    function void clear_square();
      foreach (present[i]) present[i] = 1'b0;
      foreach (where[i]) where[i] = 5'd31;
      filled = 0;
    endfunction

    function bit full();
      return filled == 25;
    endfunction

    function void place(logic [4:0] l);
      if (!present[l] && filled < 25) begin
        square[filled] = l;
        where[l] = 5'(filled);
        present[l] = 1'b1;
        filled++;
        if (filled == 25) keys_done++;
      end
    endfunction

    function void push_word(logic [4:0] l, logic st);
      cipher_word_t w;
      w.letter = l;
      w.last = 1'b0;
      w.status = st;
      due.push_back(w);
    endfunction

    // shift 1 encrypts, shift 4 decrypts
    function void cipher_digraph(logic [4:0] a, logic [4:0] b, int unsigned shift);
      int unsigned pa, pb, ar, ac, br, bc, ca, cb;
      pa = where[a];
      pb = where[b];
      ar = pa / 5;
      ac = pa % 5;
      br = pb / 5;
      bc = pb % 5;
      if (ar == br) begin
        ca = ar * 5 + (ac + shift) % 5;
        cb = br * 5 + (bc + shift) % 5;
        row_pairs++;
      end else if (ac == bc) begin
        ca = ((ar + shift) % 5) * 5 + ac;
        cb = ((br + shift) % 5) * 5 + bc;
        col_pairs++;
      end else begin
        ca = ar * 5 + bc;
        cb = br * 5 + ac;
        rect_pairs++;
      end
      push_word(square[ca], 1'b0);
      push_word(square[cb], 1'b0);
    endfunction

    function void note_word(pfc_pkg::cmd_t cmd, logic [4:0] raw, logic fin);
      logic [4:0] l;
      int first;
      first = due.size();
      l = (raw == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : raw;
      words_in++;
      if (cmd == pfc_pkg::CMD_FINISH) begin
        for (int a = 0; a < 26; a++)
          if (5'(a) != pfc_pkg::LETTER_J) place(5'(a));
        return;
      end
      if (raw > pfc_pkg::LETTER_Z) return;
      if (cmd == pfc_pkg::CMD_KEY) begin
        if (filled >= 25) begin
          clear_square();
          held_valid = 1'b0;
        end
        place(l);
        return;
      end
      if (filled < 25) return;
      if (cmd == pfc_pkg::CMD_PLAIN) begin
        if (!held_valid) begin
          if (fin) begin
            cipher_digraph(l, pfc_pkg::LETTER_X, 1);
          end else begin
            held = l;
            held_valid = 1'b1;
          end
        end else if (held == l) begin
          cipher_digraph(l, pfc_pkg::LETTER_X, 1);
          if (fin) begin
            cipher_digraph(l, pfc_pkg::LETTER_X, 1);
            held_valid = 1'b0;
          end
        end else begin
          cipher_digraph(held, l, 1);
          held_valid = 1'b0;
        end
      end else begin
        if (!held_valid) begin
          if (fin) begin
            push_word(5'd0, 1'b1);
            odd_tails++;
          end else begin
            held = l;
            held_valid = 1'b1;
          end
        end else begin
          cipher_digraph(held, l, 4);
          held_valid = 1'b0;
        end
      end
      if (due.size() > first) due[due.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      if (errors < 30) $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [7:0] data, logic fin, logic st);
      cipher_word_t w;
      words_out++;
      if (due.size() == 0) begin
        report($sformatf("word %0d unexpected: letter %0d last %0b status %0b",
                         words_out, data[4:0], fin, st));
        return;
      end
      w = due.pop_front();
      if (data[4:0] !== w.letter)
        report($sformatf("word %0d letter %0d, want %0d", words_out, data[4:0], w.letter));
      if (data[7:5] !== 3'b000)
        report($sformatf("word %0d pad bits %b, want 000", words_out, data[7:5]));
      if (fin !== w.last)
        report($sformatf("word %0d last %b, want %b", words_out, fin, w.last));
      if (st !== w.status)
        report($sformatf("word %0d status %b, want %b", words_out, st, w.status));
    endtask

    task finish_check();
      while (due.size() != 0) begin
        report($sformatf("word letter %0d never arrived", due[0].letter));
        void'(due.pop_front());
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  cipher_scoreboard sb;
  int burst_left = 0;
  int quiet = 0;
  int rx_mode = 0;
  int rx_span = 0;
  int rx_hold = 0;
  int rx_tick = 0;

  playfair_digraph_cipher i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(20, 80);
    end
    rx_span--;
    rx_tick++;
    case (rx_mode)
      0: begin
        m_tready = 1'b1;
      end
      1: begin
        m_tready = ($urandom_range(0, 2) != 0);
      end
      2: begin
        m_tready = (rx_tick % 4 != 3);
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_tready = 1'b0;
        end else begin
          m_tready = 1'b1;
          if ($urandom_range(0, 5) == 0) rx_hold = $urandom_range(2, 15);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_word(pfc_pkg::cmd_t'(s_tdata[1:0]), s_tdata[6:2], s_tlast);
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet == QUIET_LIMIT) begin
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("playfair_digraph_cipher regression: fail");
        $finish;
      end
    end
  end

  task automatic send_word(input pfc_pkg::cmd_t c, input logic [4:0] l, input logic fin);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(8, 20)) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata = {1'b0, l, c};
    s_tlast = fin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_text(input pfc_pkg::cmd_t c, input string s, input logic fin);
    for (int i = 0; i < s.len(); i++)
      send_word(c, 5'(s[i] - 8'd97), fin && (i == s.len() - 1));
  endtask

  // hold the input side until every pending result is out
  task automatic drain();
    s_tvalid = 1'b0;
    burst_left = 0;
    while (sb.due.size() != 0) @(negedge clk);
  endtask

  task automatic load_key();
    logic [4:0] deck [26];
    logic [4:0] t;
    int n;
    int k;
    if ($urandom_range(0, 4) == 0) begin
      foreach (deck[i]) deck[i] = 5'(i);
      for (int i = 25; i > 0; i--) begin
        k = $urandom_range(0, i);
        t = deck[i];
        deck[i] = deck[k];
        deck[k] = t;
      end
      foreach (deck[i]) send_word(pfc_pkg::CMD_KEY, deck[i], i == 25);
    end else begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        t = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(26, 31))
                                         : 5'($urandom_range(0, 25));
        send_word(pfc_pkg::CMD_KEY, t, (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      end
    end
    if ($urandom_range(0, 3) == 0)
      send_word(pfc_pkg::CMD_PLAIN, 5'($urandom_range(0, 25)), 1'($urandom_range(0, 1)));
    send_word(pfc_pkg::CMD_FINISH, 5'($urandom), 1'($urandom));
  endtask

  task automatic send_message(input pfc_pkg::cmd_t kind, input int n);
    logic [4:0] l;
    logic [4:0] prev;
    pfc_pkg::cmd_t c;
    logic fin;
    prev = 5'($urandom_range(0, 25));
    for (int i = 0; i < n; i++) begin
      l = ($urandom_range(0, 3) == 0) ? prev : 5'($urandom_range(0, 25));
      if ($urandom_range(0, 24) == 0) l = 5'($urandom_range(26, 31));
      c = kind;
      if ($urandom_range(0, 9) == 0)
        c = (kind == pfc_pkg::CMD_PLAIN) ? pfc_pkg::CMD_CIPHER : pfc_pkg::CMD_PLAIN;
      fin = (i == n - 1) || ($urandom_range(0, 29) == 0);
      if ($urandom_range(0, 49) == 0)
        send_word(pfc_pkg::CMD_FINISH, 5'($urandom), 1'($urandom));
      if ($urandom_range(0, 59) == 0)
        send_word(pfc_pkg::CMD_KEY, 5'($urandom_range(0, 25)), 1'b0);
      send_word(c, l, fin);
      prev = l;
    end
  endtask

  initial begin
    int n;
    bit paused;
    pfc_pkg::cmd_t kind;
    paused = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    sb = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    send_text(pfc_pkg::CMD_PLAIN, "q", 1'b1);
    send_text(pfc_pkg::CMD_KEY, "playfjirexa", 1'b1);
    send_word(pfc_pkg::CMD_KEY, 5'd31, 1'b0);
    send_word(pfc_pkg::CMD_FINISH, 5'd30, 1'b1);
    send_text(pfc_pkg::CMD_CIPHER, "d", 1'b1);
    send_text(pfc_pkg::CMD_PLAIN, "hhh", 1'b1);
    send_word(pfc_pkg::CMD_PLAIN, 5'd0, 1'b0);
    send_word(pfc_pkg::CMD_PLAIN, 5'd26, 1'b1);
    send_word(pfc_pkg::CMD_PLAIN, pfc_pkg::LETTER_Z, 1'b1);
    send_text(pfc_pkg::CMD_PLAIN, "j", 1'b1);
    send_text(pfc_pkg::CMD_CIPHER, "za", 1'b1);
    send_word(pfc_pkg::CMD_PLAIN, 5'd10, 1'b0);
    send_word(pfc_pkg::CMD_CIPHER, 5'd19, 1'b1);
    send_word(pfc_pkg::CMD_FINISH, 5'd0, 1'b0);
    send_word(pfc_pkg::CMD_PLAIN, 5'd2, 1'b0);

    while (sb.words_in < MSG_WORDS) begin
      if ($urandom_range(0, 2) == 0 || !sb.full()) load_key();
      kind = $urandom_range(0, 1) ? pfc_pkg::CMD_PLAIN : pfc_pkg::CMD_CIPHER;
      n = $urandom_range(1, 9);
      send_message(kind, n);
      if (!paused && sb.words_in >= MSG_WORDS / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.finish_check();
    $display("sent %0d words and checked %0d results over %0d completed key squares",
             sb.words_in, sb.words_out, sb.keys_done);
    $display("digraphs: %0d same row, %0d same column, %0d rectangle; %0d odd tails",
             sb.row_pairs, sb.col_pairs, sb.rect_pairs, sb.odd_tails);
    if (sb.errors == 0) begin
      $display("playfair_digraph_cipher regression: pass");
    end else begin
      $display("playfair_digraph_cipher regression: fail");
    end
    $finish;
  end

endmodule
